// ===== design/poly1305_mac_assert.svh =====
// Assertion macros used by the Poly1305 MAC engine.
`ifndef POLY1305_MAC_ASSERT_SVH
`define POLY1305_MAC_ASSERT_SVH
`ifndef ASSERT_OFF
`define P1305_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define P1305_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define P1305_ASSERT_IMPL(label, ante, cons)
`define P1305_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/p1305_pkg.sv =====
// Types and constants shared by the Poly1305 MAC modules.
package p1305_pkg;
	localparam int unsigned LIMB_W = 26;
	localparam logic [25:0] LIMB_MASK = 26'h3ffffff;

	typedef enum logic [1:0] {
		REG_R_LOW  = 2'd0,
		REG_R_HIGH = 2'd1,
		REG_S_LOW  = 2'd2,
		REG_S_HIGH = 2'd3
	} reg_idx_t;

	// One classified block passed from the front end to the engine.
	typedef struct packed {
		logic [129:0] msg;
		logic         absorb;
		logic         last;
	} job_t;
endpackage

// ===== design/p1305_front.sv =====
// Front end: pads a message block and places it in a two-entry job queue; an empty block that is not last is dropped.
module p1305_front
	import p1305_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] blk,
	input  logic [4:0]   cnt,
	input  logic         lst,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);
	job_t        q_mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fill_q;
	job_t        new_job;
	logic [4:0]  n;
	logic        push, pop;

	always_comb begin
		n = (cnt > 5'd16) ? 5'd16 : cnt;
		new_job.msg = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < n)
				new_job.msg[8*i +: 8] = blk[8*i +: 8];
			else if (5'(i) == n)
				new_job.msg[8*i +: 8] = 8'h01;
		end
		if (n == 5'd16)
			new_job.msg[128] = 1'b1;
		new_job.absorb = (n != 5'd0);
		new_job.last = lst;
	end

	assign s_tready  = (fill_q != 2'd2);
	assign job_valid = (fill_q != 2'd0);
	assign job       = q_mem_q[rd_ptr_q];
	assign push = s_tvalid && s_tready && (new_job.absorb || new_job.last);
	assign pop  = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== design/p1305_engine.sv =====
// Back end: multiply-reduce one limb row per cycle and finalise the tag.
module p1305_engine
	import p1305_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	output logic         job_ready,
	input  job_t         job,
	input  logic [127:0] r_key,
	input  logic [127:0] s_key,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] tag
);
	`include "poly1305_mac_assert.svh"

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_NORM, ST_FOLD, ST_FIN, ST_OUT} st_t;
	st_t          st_q;
	logic [2:0]   row_q;
	logic         last_q;
	logic [25:0]  h_q [5];
	logic [26:0]  a_q [5];
	logic [25:0]  rl [5];
	logic [28:0]  rs [5];
	logic [63:0]  d_q [5];
	logic [63:0]  d_n [5];
	logic [63:0]  prod;
	logic [129:0] rc;
	logic [129:0] hv;
	logic [130:0] g;
	logic [129:0] hred;
	logic [127:0] tag_q;
	logic [26:0]  ai;
	logic [63:0]  c0, c1, c2, c3, c4, c5;
	logic [63:0]  e0, e1, e2, e3, e4;
	logic [26:0]  n0, n2, n3, n4;

	always_comb begin
		rc = {2'b00, r_key & 128'h0ffffffc0ffffffc0ffffffc0fffffff};
		for (int j = 0; j < 5; j++) begin
			rl[j] = rc[26*j +: 26];
			rs[j] = 29'(rl[j]) * 29'd5;
		end
		ai = a_q[row_q];
		// row i contributes a_i*b_k to digit i+k, wrapped with *5
		for (int k = 0; k < 5; k++) begin
			if (32'(k) >= 32'(row_q))
				prod = 64'(ai) * 64'(rl[k - 32'(row_q)]);
			else
				prod = 64'(ai) * 64'(rs[k + 5 - 32'(row_q)]);
			d_n[k] = d_q[k] + prod;
		end
	end

	// carry chain of the reduction
	always_comb begin
		c0 = d_q[0] >> 26; e0 = {38'd0, d_q[0][25:0]};
		c1 = d_q[1] + c0;  e1 = {38'd0, c1[25:0]};
		c2 = d_q[2] + (c1 >> 26); e2 = {38'd0, c2[25:0]};
		c3 = d_q[3] + (c2 >> 26); e3 = {38'd0, c3[25:0]};
		c4 = d_q[4] + (c3 >> 26); e4 = {38'd0, c4[25:0]};
		c5 = e0 + (c4 >> 26) * 64'd5;
		e0 = {38'd0, c5[25:0]};
		e1 = e1 + (c5 >> 26);
	end

	// Limb 1 may reach 27 bits after the carry pass. Its top bit ripples up
	// through limbs 2 to 4; a carry out of limb 4 is worth 5 in limb 0.
	// That carry only happens when limb 1 overflowed, so limb 1 is then
	// small and can take the carry out of limb 0 without overflowing.
	always_comb begin
		n2 = 27'(d_q[2][25:0]) + 27'(d_q[1][26]);
		n3 = 27'(d_q[3][25:0]) + 27'(n2[26]);
		n4 = 27'(d_q[4][25:0]) + 27'(n3[26]);
		n0 = 27'(d_q[0][25:0]) + (n4[26] ? 27'd5 : 27'd0);
	end

	always_comb begin
		hv = {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};
		g  = 131'(hv) + 131'd5;
		hred = g[130] ? g[129:0] : hv;
	end

	assign job_ready = (st_q == ST_IDLE);
	assign m_tvalid  = (st_q == ST_OUT);
	assign tag       = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			row_q  <= 3'd0;
			last_q <= 1'b0;
			for (int j = 0; j < 5; j++) begin
				h_q[j] <= '0;
				a_q[j] <= '0;
				d_q[j] <= '0;
			end
			tag_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						last_q <= job.last;
						row_q  <= 3'd0;
						for (int j = 0; j < 5; j++) begin
							a_q[j] <= 27'(h_q[j]) + 27'(job.msg[26*j +: 26]);
							d_q[j] <= '0;
						end
						st_q <= job.absorb ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					for (int j = 0; j < 5; j++)
						d_q[j] <= d_n[j];
					row_q <= row_q + 3'd1;
					if (row_q == 3'd4)
						st_q <= ST_NORM;
				end
				ST_NORM: begin
					d_q[0] <= e0;
					d_q[1] <= e1;
					d_q[2] <= e2;
					d_q[3] <= e3;
					d_q[4] <= e4;
					st_q <= ST_FOLD;
				end
				ST_FOLD: begin
					h_q[0] <= n0[25:0];
					h_q[1] <= d_q[1][25:0] + 26'(n0[26]);
					h_q[2] <= n2[25:0];
					h_q[3] <= n3[25:0];
					h_q[4] <= n4[25:0];
					st_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					tag_q <= hred[127:0] + s_key;
					for (int j = 0; j < 5; j++)
						h_q[j] <= '0;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`P1305_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(tag))
	`P1305_ASSERT_IMPL(a_row_range, st_q == ST_MUL, row_q <= 3'd4)
	`P1305_ASSERT_NEXT(a_fin_out, st_q == ST_FIN, st_q == ST_OUT)
endmodule

// ===== design/poly1305_mac.sv =====
// Poly1305 one-time authenticator top level.
// Usage: write the 32-byte one-time key through the configuration channel
// (index 0/1 the r half, clamped internally; index 2/3 the s half) while the
// block is idle. Then stream message blocks on the s_axis channel; tdata holds
// block_low, block_high and byte_count from the lowest bit up, tlast marks the
// final block. One tag transaction appears on m_axis after each last block.
// An absorbed block occupies the engine for a load, the five limb rows of the
// 5x5 product through five 27x29 multipliers, one carry pass and one pass
// that folds the remaining carries back in. The tag then needs the final
// reduction plus s and then the output register; a last block with byte count
// zero skips the multiply and goes straight to the final reduction.
// A two-entry queue lets the front end take blocks while the engine works.
// If the receiver stalls, the tag holds on m_axis and the queue fills,
// after which s_axis_tready falls.
// Reset clears the key registers, the accumulator and the queue.
module poly1305_mac
	import p1305_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // block_low, block_high, byte_count, pad
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // tag_low, tag_high
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	logic [63:0] key_q [4];
	logic        job_valid, job_ready;
	job_t        job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				key_q[i] <= '0;
		end else if (cfg_valid) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	p1305_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.blk       (s_axis_tdata[127:0]),
		.cnt       (s_axis_tdata[132:128]),
		.lst       (s_axis_tlast),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	p1305_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.r_key     ({key_q[REG_R_HIGH], key_q[REG_R_LOW]}),
		.s_key     ({key_q[REG_S_HIGH], key_q[REG_S_LOW]}),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.tag       (m_axis_tdata)
	);
endmodule

// ===== tb/sv/poly1305_mac_tb.sv =====
// Self-checking testbench for the Poly1305 MAC: directed table, then random messages.
`timescale 1ns / 1ps

module poly1305_mac_tb;
	import p1305_pkg::*;

	localparam logic [129:0] PRIME = (130'd1 << 130) - 130'd5;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;

	poly1305_mac DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the key registers and of the accumulator (kept fully reduced).
	logic [63:0]  key_words [4];
	logic [129:0] acc_h;
	logic [127:0] tag_queue [$];
	int           errors;
	int           tags_seen;
	int           blocks_sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Timeout waiting for the block to finish");
		$display("Mismatches found");
		$finish;
	end

	// Absorb one block into the shadow accumulator, padding as the standard requires.
	function automatic void absorb_block(logic [63:0] lo, logic [63:0] hi, int n);
		logic [129:0] msg;
		logic [127:0] r;
		logic [259:0] prod;
		logic [127:0] data;
		data = {hi, lo};
		if (n >= 16) begin
			msg = {2'b01, data};
		end else begin
			data = data & ((128'd1 << (8 * n)) - 128'd1);
			msg = {2'b00, data | (128'd1 << (8 * n))};
		end
		r = {key_words[REG_R_HIGH], key_words[REG_R_LOW]}
			& 128'h0ffffffc0ffffffc0ffffffc0fffffff;
		prod = (260'(acc_h) + 260'(msg)) * 260'(r);
		acc_h = 130'(prod % 260'(PRIME));
	endfunction

	// Work out the effect of one accepted input transaction.
	function automatic void predict_item(logic [63:0] lo, logic [63:0] hi,
			logic [4:0] cnt, logic last);
		int n;
		n = (cnt > 5'd16) ? 16 : int'(cnt);
		if (n > 0)
			absorb_block(lo, hi, n);
		if (last) begin
			tag_queue.push_back(acc_h[127:0] + {key_words[REG_S_HIGH], key_words[REG_S_LOW]});
			acc_h = '0;
		end
	endfunction

	// Idle gap before the next input transaction; valid only drops when there is a gap.
	task automatic pause_cycles();
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic last);
		pause_cycles();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, cnt, hi, lo};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(lo, hi, cnt, last);
		blocks_sent++;
	endtask

	// Leaves cfg_valid high; the caller drops it after its last write.
	task automatic write_key(reg_idx_t idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		key_words[idx] = value;
	endtask

	// Drain outstanding tags, then give the engine time to settle before touching the key.
	task automatic wait_idle();
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (tag_queue.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	// Receiver: random wait before each tag, compares it with the oldest expectation.
	initial begin
		logic [127:0] want;
		int           wait_n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = $urandom_range(0, 7);
			if (wait_n != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			tags_seen++;
			if (tag_queue.size() == 0) begin
				$error("unexpected tag transaction %h", m_axis_tdata);
				errors++;
			end else begin
				want = tag_queue.pop_front();
				if (m_axis_tdata[63:0] !== want[63:0]) begin
					$error("tag_low expected %h actual %h", want[63:0], m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== want[127:64]) begin
					$error("tag_high expected %h actual %h",
						want[127:64], m_axis_tdata[127:64]);
					errors++;
				end
			end
		end
	end

	typedef struct {
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [4:0]   cnt;
		logic         last;
		logic         check_fixed;
		logic [127:0] fixed_tag;
	} block_row_t;

	// Directed rows. With a zero key every tag equals s; after reset s is zero too.
	block_row_t directed_rows [] = '{
		'{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b1, 128'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b1, 1'b1, 128'h0},
		'{64'hffffffffffffffff, 64'h0, 5'd0, 1'b0, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1, 1'b1, 1'b0, 128'h0},
		'{64'h1122334455667788, 64'h99aabbccddeeff00, 5'd7, 1'b1, 1'b0, 128'h0},
		'{64'h1122334455667788, 64'h99aabbccddeeff00, 5'd8, 1'b1, 1'b0, 128'h0},
		'{64'h1122334455667788, 64'h99aabbccddeeff00, 5'd9, 1'b1, 1'b0, 128'h0},
		'{64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 5'd15, 1'b0, 1'b0, 128'h0},
		'{64'h0, 64'h0, 5'd0, 1'b1, 1'b0, 128'h0},
		'{64'h0, 64'h0, 5'd16, 1'b0, 1'b0, 128'h0},
		'{64'h0, 64'h0, 5'd16, 1'b1, 1'b0, 128'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd17, 1'b1, 1'b0, 128'h0}
	};

	initial begin
		logic [63:0] lo, hi;
		logic [4:0]  cnt;
		int          len;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_R_LOW;
		cfg_data      = '0;
		errors        = 0;
		tags_seen     = 0;
		blocks_sent   = 0;
		acc_h         = '0;
		foreach (key_words[i]) key_words[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first three rows run under the reset key and have a fixed expectation.
		foreach (directed_rows[i]) begin
			if (i == 3) begin
				wait_idle();
				write_key(REG_R_LOW, 64'hffffffffffffffff);
				write_key(REG_R_HIGH, 64'hffffffffffffffff);
				write_key(REG_S_LOW, 64'hffffffffffffffff);
				write_key(REG_S_HIGH, 64'hffffffffffffffff);
				cfg_valid <= 1'b0;
			end
			send_block(directed_rows[i].lo, directed_rows[i].hi,
				directed_rows[i].cnt, directed_rows[i].last);
			if (directed_rows[i].check_fixed && directed_rows[i].last
					&& tag_queue[$] !== directed_rows[i].fixed_tag) begin
				$error("predictor tag expected %h actual %h",
					directed_rows[i].fixed_tag, tag_queue[$]);
				errors++;
			end
		end

		// Random messages under a series of keys, mostly well formed.
		while (blocks_sent < 2000) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: begin
					write_key(REG_R_LOW, '0);
					write_key(REG_S_HIGH, '1);
				end
				1: begin
					write_key(REG_R_HIGH, '1);
					write_key(REG_S_LOW, '0);
				end
				default: begin
					write_key(REG_R_LOW, {$urandom, $urandom});
					write_key(REG_R_HIGH, {$urandom, $urandom});
					write_key(REG_S_LOW, {$urandom, $urandom});
					write_key(REG_S_HIGH, {$urandom, $urandom});
				end
			endcase
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) begin
				len = $urandom_range(0, 6);
				for (int b = 0; b <= len; b++) begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
					if (b < len)
						cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
					else
						cnt = 5'($urandom_range(0, 31));
					send_block(lo, hi, cnt, b == len);
				end
			end
		end

		wait_idle();
		if (tag_queue.size() != 0) begin
			$error("%0d tags never arrived", tag_queue.size());
			errors++;
		end
		$display("Run covered %0d message blocks and %0d tags over several keys,",
			blocks_sent, tags_seen);
		$display("including empty, partial, oversized and ignored blocks.");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/p1305_pkg.sv
design/p1305_front.sv
design/p1305_engine.sv
design/poly1305_mac.sv
tb/sv/poly1305_mac_tb.sv
